>>> rtl/greedy_line_wrap_align_top_assert.svh
// assertion macros shared by the rtl of the greedy line wrapper
`ifndef GREEDY_LINE_WRAP_ALIGN_TOP_ASSERT_SVH
`define GREEDY_LINE_WRAP_ALIGN_TOP_ASSERT_SVH

// checked only out of reset
`define GLWA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GLWA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/glwa_pkg.sv
// constants, types and helpers of the greedy line wrapper
`default_nettype none

package glwa_pkg;

    localparam int COORD_W         = 16;
    localparam int TOK_W           = 12;
    localparam int SUM_W           = 18;
    localparam int ALIGN_W         = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int LINE_TOKENS_DEF = 32;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SUM_W-1:0]   t_sum;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_INDENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MODE    = 2'd2;

    localparam logic [ALIGN_W-1:0] ALIGN_LEFT   = 2'd0;
    localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 2'd1;
    localparam logic [ALIGN_W-1:0] ALIGN_RIGHT  = 2'd2;

    localparam t_coord     WRAP_WIDTH_RST = 16'd640;
    localparam logic [2:0] HEIGHT_PAD     = 3'd5;

    // clamp a wide sum to the coordinate range
    function automatic t_coord sat_coord(input t_sum v);
        return (v[SUM_W-1:COORD_W] != '0) ? {COORD_W{1'b1}} : v[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/glwa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module glwa_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/greedy_line_wrap_align_top.sv
// greedy line wrapper with per-line left, center or right alignment
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one token box per transaction:
//   width, height and an end-of-block mark. Output channel (o_out_valid /
//   i_out_stall) gives one placed token per transaction when a line closes.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes wrap width,
//   second indent and align mode; write only while the block is idle.
// Sequencing:
//   One sequencer with one shared adder works on a single token at a time.
//   A token that closes no line passes through decide, place and store.
//   Each closed line takes one step for the shift, then for each buffered
//   token a ram read, an add and a present; a final token adds a height step
//   before the flush and a clear after it. o_in_stall stays high until the
//   sequencer is back in idle, so no new token is taken while one is in work.
//   The line buffer read port sets the per-token cost.
// Reset (synchronous, active low) clears the layout, restores the registers
// and drops o_out_valid. A stall on the output holds the result and the
// sequencer; o_in_stall stays high until the item is fully done.
`default_nettype none

module greedy_line_wrap_align_top #(
    parameter int LINE_TOKENS = glwa_pkg::LINE_TOKENS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [glwa_pkg::TOK_W-1:0]    i_token_width,
    input  wire logic [glwa_pkg::TOK_W-1:0]    i_token_height,
    input  wire logic                          i_end_of_block,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [glwa_pkg::COORD_W-1:0]       o_token_x,
    output logic [glwa_pkg::COORD_W-1:0]       o_token_y,
    output logic                               o_last_of_run,
    output logic                               o_block_end,
    output logic [glwa_pkg::COORD_W-1:0]       o_block_height,
    output logic                               o_line_overflow,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [glwa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [glwa_pkg::COORD_W-1:0]  i_cfg_data
);

    `include "greedy_line_wrap_align_top_assert.svh"

    localparam int CNT_W = $clog2(LINE_TOKENS + 1);
    localparam int IDX_W = (LINE_TOKENS > 1) ? $clog2(LINE_TOKENS) : 1;
    localparam int CW    = glwa_pkg::COORD_W;
    localparam int SW    = glwa_pkg::SUM_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_DX     = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_LD     = 4'd4;
    localparam logic [3:0] S_HOLD   = 4'd5;
    localparam logic [3:0] S_PLACE  = 4'd6;
    localparam logic [3:0] S_STORE  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_CLEAR  = 4'd9;

    logic [3:0] r_state;

    // configuration
    glwa_pkg::t_coord               r_wrap_width;
    glwa_pkg::t_coord               r_second_indent;
    logic [glwa_pkg::ALIGN_W-1:0]   r_align_mode;

    // layout state
    glwa_pkg::t_coord               r_cursor;
    glwa_pkg::t_coord               r_top;
    logic [glwa_pkg::TOK_W-1:0]     r_tallest;
    glwa_pkg::t_coord               r_edge;
    logic [CNT_W-1:0]               r_count;

    // current transaction
    logic [glwa_pkg::TOK_W-1:0]     r_w;
    logic [glwa_pkg::TOK_W-1:0]     r_h;
    logic                           r_last;
    logic                           r_wrap;
    logic                           r_ovf;
    logic                           r_final;
    glwa_pkg::t_coord               r_dx;
    glwa_pkg::t_coord               r_height;
    logic [CNT_W-1:0]               r_idx;

    // output register
    logic                           r_out_valid;
    glwa_pkg::t_coord               r_out_x;
    glwa_pkg::t_coord               r_out_y;
    logic                           r_out_last;
    logic                           r_out_block_end;
    glwa_pkg::t_coord               r_out_height;
    logic                           r_out_ovf;

    // shared adder
    glwa_pkg::t_sum                 u_a;
    glwa_pkg::t_sum                 u_b;
    logic [2:0]                     u_c;
    glwa_pkg::t_sum                 u_sum;
    glwa_pkg::t_sum                 u_dec;

    glwa_pkg::t_coord               ram_q;
    logic                           ram_we;
    logic                           in_acc;
    logic                           out_acc;
    logic                           last_idx;
    logic                           room_pos;
    glwa_pkg::t_coord               edge_new;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign last_idx = ((r_idx + CNT_W'(1)) == r_count);
    assign ram_we   = (r_state == S_STORE);

    always_comb begin
        u_a = '0;
        u_b = '0;
        u_c = '0;
        unique case (r_state) inside
            S_DECIDE, S_STORE: begin
                u_a = SW'(r_cursor);
                u_b = SW'(r_w);
            end
            S_DX: begin
                u_a = SW'(r_wrap_width);
                u_b = ~SW'(r_edge);
                u_c = 3'd1;
            end
            S_LD: begin
                u_a = SW'(ram_q);
                u_b = SW'(r_dx);
            end
            S_PLACE: begin
                u_a = SW'(r_top);
                u_b = SW'(r_tallest);
            end
            S_FIN: begin
                u_a = SW'(r_top);
                u_b = SW'(r_tallest);
                u_c = glwa_pkg::HEIGHT_PAD;
            end
            default: begin
                u_a = '0;
            end
        endcase
        u_sum = u_a + u_b + SW'(u_c);
        u_dec = u_sum - SW'(1);
    end

    assign room_pos = !u_sum[SW-1] && (u_sum[SW-2:0] != '0);
    assign edge_new = glwa_pkg::sat_coord(u_dec);

    glwa_ram #(
        .WIDTH (CW),
        .DEPTH (LINE_TOKENS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_cursor),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width    <= glwa_pkg::WRAP_WIDTH_RST;
            r_second_indent <= '0;
            r_align_mode    <= glwa_pkg::ALIGN_LEFT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                glwa_pkg::CFG_WRAP_WIDTH:    r_wrap_width    <= i_cfg_data;
                glwa_pkg::CFG_SECOND_INDENT: r_second_indent <= i_cfg_data;
                glwa_pkg::CFG_ALIGN_MODE: begin
                    r_align_mode <= i_cfg_data[glwa_pkg::ALIGN_W-1:0];
                end
                default: begin
                    r_align_mode <= r_align_mode;
                end
            endcase
        end
    end

    // sequencer and layout state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_top       <= '0;
            r_tallest   <= '0;
            r_edge      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_wrap      <= 1'b0;
            r_ovf       <= 1'b0;
            r_final     <= 1'b0;
            r_idx       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_w     <= i_token_width;
                        r_h     <= i_token_height;
                        r_last  <= i_end_of_block;
                        r_final <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_wrap <= (u_sum >= SW'(r_wrap_width));
                    r_ovf  <= 1'b0;
                    if (u_sum >= SW'(r_wrap_width)) begin
                        r_state <= (r_count != '0) ? S_DX : S_PLACE;
                    end else if (r_count == CNT_W'(LINE_TOKENS)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_DX;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_DX: begin
                    r_idx <= '0;
                    if (!room_pos) begin
                        r_dx <= '0;
                    end else begin
                        case (r_align_mode)
                            glwa_pkg::ALIGN_CENTER: r_dx <= {1'b0, u_sum[CW-1:1]};
                            glwa_pkg::ALIGN_RIGHT:  r_dx <= u_sum[CW-1:0];
                            default:                r_dx <= '0;
                        endcase
                    end
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_out_valid     <= 1'b1;
                    r_out_x         <= glwa_pkg::sat_coord(u_sum);
                    r_out_y         <= r_top;
                    r_out_ovf       <= r_ovf;
                    r_out_last      <= last_idx && (r_final || !r_last);
                    r_out_block_end <= last_idx && r_final;
                    r_out_height    <= (last_idx && r_final) ? r_height : '0;
                    r_state         <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        if (last_idx) begin
                            r_count <= '0;
                            r_edge  <= '0;
                            r_state <= r_final ? S_CLEAR : S_PLACE;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_PLACE: begin
                    if (r_wrap) begin
                        r_top     <= glwa_pkg::sat_coord(u_sum);
                        r_tallest <= '0;
                        r_cursor  <= r_second_indent;
                    end
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    r_count  <= r_count + CNT_W'(1);
                    r_cursor <= glwa_pkg::sat_coord(u_sum);
                    if ((u_sum != '0) && (edge_new > r_edge)) begin
                        r_edge <= edge_new;
                    end
                    if (r_h > r_tallest) begin
                        r_tallest <= r_h;
                    end
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_height <= glwa_pkg::sat_coord(u_sum);
                    r_final  <= 1'b1;
                    r_ovf    <= 1'b0;
                    r_state  <= S_DX;
                end
                S_CLEAR: begin
                    r_cursor  <= '0;
                    r_top     <= '0;
                    r_tallest <= '0;
                    r_edge    <= '0;
                    r_count   <= '0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_token_x       = r_out_x;
    assign o_token_y       = r_out_y;
    assign o_last_of_run   = r_out_last;
    assign o_block_end     = r_out_block_end;
    assign o_block_height  = r_out_height;
    assign o_line_overflow = r_out_ovf;

    `GLWA_ASSERT(a_count_bound, r_count <= CNT_W'(LINE_TOKENS), "line buffer count over depth")
    `GLWA_ASSERT_ALWAYS(a_valid_in_hold, r_out_valid |-> (r_state == S_HOLD), "result outside hold")
    `GLWA_ASSERT(a_accept_start, in_acc |=> (r_state == S_DECIDE), "accept did not start work")
    `GLWA_ASSERT(a_end_is_last, (r_out_valid && r_out_block_end) |-> r_out_last, "block end not last")
    `GLWA_ASSERT(a_clear_layout, (r_state == S_CLEAR) |=> (r_count == '0 && r_cursor == '0), "no clear")

endmodule

`default_nettype wire

>>> bench/greedy_line_wrap_align_top_tb.sv
// self-checking testbench for the greedy line wrapper: directed table, then random layout phases
`timescale 1ns / 100ps

module greedy_line_wrap_align_top_tb;
    import glwa_pkg::*;

    localparam int          LINE_TOKENS   = LINE_TOKENS_DEF;
    localparam int          RAND_ITEMS    = 185;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_LIMIT   = 50000;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int          DIR_ROWS      = 25;

    localparam logic [ALIGN_W-1:0] ALIGN_UNUSED = 2'd3;

    typedef struct {
        t_coord pos_x;
        t_coord pos_y;
        logic   last_run;
        logic   blk_end;
        t_coord blk_height;
        logic   overflow;
    } t_placed_tok;

    typedef enum logic {ROW_TOKEN, ROW_WRITE} t_dir_kind;

    typedef struct {
        t_dir_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        t_coord                 reg_val;
        logic [TOK_W-1:0]       w;
        logic [TOK_W-1:0]       h;
        logic                   eob;
        bit                     typed;
        t_coord                 tx;
        t_coord                 ty;
        t_coord                 th;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [TOK_W-1:0]       i_token_width;
    logic [TOK_W-1:0]       i_token_height;
    logic                   i_end_of_block;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_coord                 o_token_x;
    t_coord                 o_token_y;
    logic                   o_last_of_run;
    logic                   o_block_end;
    t_coord                 o_block_height;
    logic                   o_line_overflow;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    t_coord                 i_cfg_data;

    greedy_line_wrap_align_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_token_width   (i_token_width),
        .i_token_height  (i_token_height),
        .i_end_of_block  (i_end_of_block),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_x       (o_token_x),
        .o_token_y       (o_token_y),
        .o_last_of_run   (o_last_of_run),
        .o_block_end     (o_block_end),
        .o_block_height  (o_block_height),
        .o_line_overflow (o_line_overflow),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // layout tracker state and register copies
    t_coord             cfg_wrap;
    t_coord             cfg_indent;
    logic [ALIGN_W-1:0] cfg_align;
    int unsigned        cur_x;
    int unsigned        top_y;
    int unsigned        tallest;
    int unsigned        right_edge;
    int unsigned        tok_cnt;
    int unsigned        tok_x [LINE_TOKENS];

    t_placed_tok placed_q [$];
    t_placed_tok step_res_q [$];
    t_placed_tok head_tok;
    t_placed_tok no_typed;

    int          fail_cnt;
    int          rand_items;
    int unsigned cycle_cnt;
    bit          quiet;
    bit          hold_req;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd0, 12'd0, 1'b1, 1'b1, 16'd0, 16'd0, 16'd5},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd4095, 12'd4095, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd1, 12'd1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_WRAP_WIDTH, 16'd100, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_ALIGN_MODE, t_coord'(ALIGN_CENTER), 12'd0, 12'd0, 1'b0, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd10, 12'd3, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd30, 12'd7, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_ALIGN_MODE, t_coord'(ALIGN_RIGHT), 12'd0, 12'd0, 1'b0, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd50, 12'd2, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd50, 12'd9, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd0, 12'd0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_ALIGN_MODE, t_coord'(ALIGN_UNUSED), 12'd0, 12'd0, 1'b0, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_SECOND_INDENT, 16'd65535, 12'd0, 12'd0, 1'b0, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd60, 12'd1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd60, 12'd1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd4095, 12'd4095, 1'b1, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_SECOND_INDENT, 16'd0, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_WRAP_WIDTH, 16'd1, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_ALIGN_MODE, t_coord'(ALIGN_LEFT), 12'd0, 12'd0, 1'b0, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd0, 12'd5, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd1, 12'd4095, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd0, 12'd0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_WRAP_WIDTH, 16'd65535, 12'd0, 12'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_WRITE, CFG_ALIGN_MODE, t_coord'(ALIGN_CENTER), 12'd0, 12'd0, 1'b0, 1'b0,
          16'd0, 16'd0, 16'd0},
        '{ROW_TOKEN, CFG_WRAP_WIDTH, 16'd0, 12'd4095, 12'd0, 1'b1, 1'b1,
          16'd30720, 16'd0, 16'd5}
    };

    function automatic int unsigned clamp16(input int unsigned v);
        return (v > 32'd65535) ? 32'd65535 : v;
    endfunction

    task automatic flag_mismatch(input string msg);
        fail_cnt++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic reset_layout();
        cur_x      = 0;
        top_y      = 0;
        tallest    = 0;
        right_edge = 0;
        tok_cnt    = 0;
    endtask

    task automatic flush_line(input logic ovf);
        int unsigned dx;
        int unsigned i;
        t_placed_tok r;
        dx = 0;
        if (cfg_wrap > right_edge) begin
            if (cfg_align == ALIGN_CENTER) begin
                dx = (cfg_wrap - right_edge) / 2;
            end else if (cfg_align == ALIGN_RIGHT) begin
                dx = cfg_wrap - right_edge;
            end
        end
        for (i = 0; i < tok_cnt; i++) begin
            r.pos_x      = t_coord'(clamp16(tok_x[i] + dx));
            r.pos_y      = t_coord'(clamp16(top_y));
            r.last_run   = 1'b0;
            r.blk_end    = 1'b0;
            r.blk_height = '0;
            r.overflow   = ovf;
            step_res_q.push_back(r);
        end
        tok_cnt    = 0;
        right_edge = 0;
    endtask

    // places one token and collects the tokens it releases in step_res_q
    task automatic place_token(input int unsigned w, input int unsigned h, input logic eob);
        int unsigned x;
        int unsigned height;
        int          idx;
        height = 0;
        step_res_q.delete();
        if (cur_x + w >= cfg_wrap) begin
            if (tok_cnt > 0) begin
                flush_line(1'b0);
            end
            top_y   = clamp16(top_y + tallest);
            tallest = 0;
            cur_x   = cfg_indent;
        end else if (tok_cnt >= LINE_TOKENS) begin
            flush_line(1'b1);
        end
        x = cur_x;
        if (tok_cnt < LINE_TOKENS) begin
            tok_x[tok_cnt] = x;
            tok_cnt++;
        end
        if (x + w > 0 && clamp16(x + w - 1) > right_edge) begin
            right_edge = clamp16(x + w - 1);
        end
        if (h > tallest) begin
            tallest = h;
        end
        cur_x = clamp16(x + w);
        if (eob) begin
            flush_line(1'b0);
            height = clamp16(top_y + tallest + HEIGHT_PAD);
            reset_layout();
        end
        if (step_res_q.size() > 0) begin
            idx = step_res_q.size() - 1;
            step_res_q[idx].last_run = 1'b1;
            if (eob) begin
                step_res_q[idx].blk_end    = 1'b1;
                step_res_q[idx].blk_height = t_coord'(height);
            end
        end
    endtask

    task automatic send_token(input logic [TOK_W-1:0] w, input logic [TOK_W-1:0] h,
                              input logic eob, input bit typed, input t_placed_tok want);
        int gap;
        i_in_valid     <= 1'b1;
        i_token_width  <= w;
        i_token_height <= h;
        i_end_of_block <= eob;
        do @(posedge i_clk); while (o_in_stall);
        place_token(w, h, eob);
        if (typed) begin
            placed_q.push_back(want);
        end else begin
            foreach (step_res_q[k]) placed_q.push_back(step_res_q[k]);
        end
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // registers change only with the layout engine idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_coord val);
        i_in_valid <= 1'b0;
        while (placed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WRAP_WIDTH:    cfg_wrap   = val;
            CFG_SECOND_INDENT: cfg_indent = val;
            CFG_ALIGN_MODE:    cfg_align  = val[ALIGN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_layout(input t_coord wrap, input t_coord indent, input t_coord align);
        write_reg(CFG_WRAP_WIDTH, wrap);
        write_reg(CFG_SECOND_INDENT, indent);
        write_reg(CFG_ALIGN_MODE, align);
    endtask

    task automatic run_block(input int n_tok, input int wmax, input bit tall);
        logic [TOK_W-1:0] w;
        logic [TOK_W-1:0] h;
        logic             eob;
        int               k;
        int               sel;
        for (k = 0; k < n_tok; k++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                w = '0;
            end else if (sel == 1) begin
                w = TOK_W'(wmax);
            end else begin
                w = TOK_W'($urandom_range(0, wmax));
            end
            sel = $urandom_range(0, 9);
            if (tall || sel == 1) begin
                h = '1;
            end else if (sel == 0) begin
                h = '0;
            end else begin
                h = TOK_W'($urandom_range(0, 4095));
            end
            // occasional early end of block breaks the sequence
            eob = (k == n_tok - 1) || ($urandom_range(0, 24) == 0);
            send_token(w, h, eob, 1'b0, no_typed);
            rand_items++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    // output side: random stalls per transaction plus one long hold-off
    initial begin
        int n;
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = quiet ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (placed_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected transaction x=%0d y=%0d",
                                        o_token_x, o_token_y));
            end else begin
                head_tok = placed_q.pop_front();
                if (o_token_x !== head_tok.pos_x || o_token_y !== head_tok.pos_y ||
                    o_last_of_run !== head_tok.last_run || o_block_end !== head_tok.blk_end ||
                    o_block_height !== head_tok.blk_height ||
                    o_line_overflow !== head_tok.overflow) begin
                    flag_mismatch($sformatf(
                        "got x=%0d y=%0d last=%0b end=%0b h=%0d ovf=%0b want %0d %0d %0b %0b %0d %0b",
                        o_token_x, o_token_y, o_last_of_run, o_block_end, o_block_height,
                        o_line_overflow, head_tok.pos_x, head_tok.pos_y, head_tok.last_run,
                        head_tok.blk_end, head_tok.blk_height, head_tok.overflow));
                end
            end
        end
    end

    initial begin
        t_placed_tok typed_res;
        int          phase;
        int          start;
        int          drain;
        int          n_lo;
        int          n_hi;
        int          wmax;
        bit          tall;
        bit          pressed;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_token_width  <= '0;
        i_token_height <= '0;
        i_end_of_block <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        fail_cnt   = 0;
        rand_items = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        pressed    = 1'b0;
        no_typed   = '{default: '0};
        cfg_wrap   = WRAP_WIDTH_RST;
        cfg_indent = '0;
        cfg_align  = ALIGN_LEFT;
        reset_layout();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                typed_res = '{dir_rows[r].tx, dir_rows[r].ty, 1'b1, dir_rows[r].eob,
                              dir_rows[r].th, 1'b0};
                send_token(dir_rows[r].w, dir_rows[r].h, dir_rows[r].eob,
                           dir_rows[r].typed, typed_res);
            end
        end

        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            tall = 1'b0;
            case (phase % 6)
                0: begin
                    set_layout(t_coord'($urandom_range(200, 2000)),
                               t_coord'($urandom_range(0, 300)),
                               t_coord'($urandom_range(0, 3)));
                    n_lo = 1;  n_hi = 12; wmax = 600;
                end
                1: begin
                    // long lines overrun the line buffer
                    set_layout(16'd65535, t_coord'($urandom_range(0, 100)),
                               t_coord'(ALIGN_CENTER));
                    n_lo = 33; n_hi = 40; wmax = 60;
                end
                2: begin
                    // each token of nonzero width starts a new line, tall boxes push y into saturation
                    set_layout(16'd1, 16'd0, t_coord'(ALIGN_RIGHT));
                    n_lo = 18; n_hi = 22; wmax = 3; tall = 1'b1;
                end
                3: begin
                    set_layout(t_coord'($urandom_range(1, 65535)),
                               t_coord'($urandom_range(0, 65535)),
                               t_coord'($urandom_range(0, 3)));
                    n_lo = 1;  n_hi = 10; wmax = 4095;
                end
                4: begin
                    // indent at the top of the range saturates x
                    set_layout(16'd65535, 16'd65535, t_coord'(ALIGN_RIGHT));
                    n_lo = 17; n_hi = 24; wmax = 4095;
                end
                default: begin
                    set_layout(t_coord'($urandom_range(1000, 8000)),
                               t_coord'($urandom_range(0, 500)),
                               t_coord'(ALIGN_LEFT));
                    n_lo = 2;  n_hi = 12; wmax = 4095;
                end
            endcase
            start = rand_items;
            while (rand_items - start < 25) begin
                quiet = ($urandom_range(0, 4) == 0);
                if (phase % 6 == 1 && !pressed) begin
                    pressed  = 1'b1;
                    quiet    = 1'b1;
                    hold_req = 1'b1;
                end
                run_block($urandom_range(n_lo, n_hi), wmax, tall);
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        drain = 0;
        while (placed_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (placed_q.size() != 0) begin
            flag_mismatch($sformatf("%0d placed tokens never came out", placed_q.size()));
        end
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/glwa_pkg.sv
rtl/glwa_ram.sv
rtl/greedy_line_wrap_align_top.sv
bench/greedy_line_wrap_align_top_tb.sv
